// ----- rtl/core/mhpq_pkg.sv -----
// ----------------------------------------------------------------------------
// mhpq_pkg: shared types and constants
// Value type, command word to the cell row, operation and status codes.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;

  typedef logic signed [VAL_W-1:0] word_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic  ins;
    logic  rem;
    word_t val;
  } cmd_t;

endpackage

// ----- rtl/core/mhpq_cell.sv -----
// ----------------------------------------------------------------------------
// mhpq_cell: one slot of the sorted queue row
// Holds one value; on insert keeps, takes the new word or takes the left
// neighbor's value; on remove takes the right neighbor's value.
// ----------------------------------------------------------------------------
module mhpq_cell
  import mhpq_pkg::*;
(
  input  logic  clk,
  input  cmd_t  cmd,
  input  logic  valid,
  input  logic  left_stay,
  input  word_t left_val,
  input  word_t right_val,
  output logic  stay,
  output word_t val_r
);

  word_t val_nxt;

  // cell keeps its value when it is occupied and not below the new word
  assign stay = valid && !(cmd.val > val_r);

  always_comb begin
    val_nxt = val_r;
    if (cmd.ins) begin
      if (stay) begin
        val_nxt = val_r;
      end else if (left_stay) begin
        val_nxt = cmd.val;
      end else begin
        val_nxt = left_val;
      end
    end else if (cmd.rem) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// ----- rtl/core/max_heap_priority_queue_core.sv -----
// ----------------------------------------------------------------------------
// max_heap_priority_queue_core: max priority queue of signed 32-bit words
// The result word is registered and valid in the cycle after the input word is accepted.
// Throughput: 1 word per cycle while the output is not stalled; the whole cell row updates at once.
// Input ready drops only while a result waits and the output is stalled.
// Reset (rst_n low, synchronous) empties the queue and drops out_tvalid;
// cell contents are not cleared.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_core
  import mhpq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value_in
  input  logic        in_tuser,   // [0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] value_out, [36:32] count_out, [39:37] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  logic        acc;
  logic        full;
  logic        empty;
  cmd_t        cmd;
  cnt_t        cnt_r, cnt_nxt;
  logic        out_valid_r;
  word_t       out_val_r;
  cnt_t        out_cnt_r;
  logic [1:0]  out_st_r;
  logic [1:0]  st;
  word_t       res_val;

  word_t       cell_val [CAPACITY];
  logic [CAPACITY-1:0] cell_stay;

  assign in_tready = !out_valid_r || out_tready;
  assign acc       = in_tvalid && in_tready;
  assign full      = (cnt_r == cnt_t'(CAPACITY));
  assign empty     = (cnt_r == '0);

  assign cmd.ins = acc && (in_tuser == FUNC_INSERT) && !full;
  assign cmd.rem = acc && (in_tuser == FUNC_REMOVE) && !empty;
  assign cmd.val = word_t'(in_tdata);

  always_comb begin
    cnt_nxt = cnt_r;
    st      = ST_OK;
    res_val = '0;
    if (in_tuser == FUNC_INSERT) begin
      if (full) begin
        st = ST_FULL;
      end else begin
        cnt_nxt = cnt_r + cnt_t'(1);
      end
    end else begin
      if (empty) begin
        st = ST_EMPTY;
      end else begin
        cnt_nxt = cnt_r - cnt_t'(1);
        res_val = cell_val[0];
      end
    end
  end

  // descending row: cell 0 holds the maximum
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic  l_stay;
    word_t l_val;
    word_t r_val;
    if (i == 0) begin : g_first
      assign l_stay = 1'b1;
      assign l_val  = '0;
    end else begin : g_mid
      assign l_stay = cell_stay[i-1];
      assign l_val  = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign r_val = '0;
    end else begin : g_inner
      assign r_val = cell_val[i+1];
    end
    mhpq_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .valid     (cnt_r > cnt_t'(i)),
      .left_stay (l_stay),
      .left_val  (l_val),
      .right_val (r_val),
      .stay      (cell_stay[i]),
      .val_r     (cell_val[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        cnt_r <= cnt_nxt;
      end
      if (acc) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_val_r <= res_val;
      out_cnt_r <= cnt_nxt;
      out_st_r  <= st;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, 5'(out_cnt_r), 32'(out_val_r)};
  assign out_tuser  = out_st_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cnt_t'(CAPACITY))
    else $error("element count above capacity");

  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r >= cnt_t'(2) |-> cell_val[0] >= cell_val[1])
    else $error("head cells out of order");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_st_r != ST_OK |-> out_val_r == '0)
    else $error("refused operation returned a value");

  a_ins_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |=> cnt_r == $past(cnt_r) + cnt_t'(1))
    else $error("insert did not bump count");

  a_rem_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rem |=> cnt_r == $past(cnt_r) - cnt_t'(1))
    else $error("remove did not drop count");

endmodule
